FILE: sv/rwps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// rank weighted parent select block.
// ----------------------------------------------------------------------------
package rwps_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int NW   = 2 * CW + 1;
  localparam int DW   = NW + 16;
  localparam int SUMW = 32;
  localparam int CMPW = SUMW + 8;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Result kinds carried in the output tuser.
  localparam logic KIND_FITTEST = 1'b0;
  localparam logic KIND_PARENT  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_POP_SIZE = 1'b0;
  localparam logic REG_SLOPE    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_RK,
    ST_RK_ADDR,
    ST_RK_CAP,
    ST_RK_SCAN,
    ST_RK_WR,
    ST_RK_DONE,
    ST_SEL_M1,
    ST_SEL_M2,
    ST_SEL_WALK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic load_we;
    logic i_clr;
    logic i_inc;
    logic rd_i;
    logic cap_fi;
    logic sweep_clr;
    logic sweep_run;
    logic sel_mode;
    logic rank_we;
    logic mul1;
    logic mul2;
    logic res_fit;
    logic res_found;
    logic res_nf;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic hit;
    logic i_last;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: sv/rwps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rwps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rwps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_ctrl
// Sequencer for loads, the ranking sweeps and the selection walk.
// ----------------------------------------------------------------------------
module rwps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tuser_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  input  rwps_pkg::dp_sts_t sts_i,
  output rwps_pkg::dp_cmd_t cmd_o
);
  import rwps_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser_i == OP_SELECT) begin
            state_d = ST_SEL_M1;
          end else if (s_tlast_i) begin
            state_d = ST_LOAD_RK;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD:     state_d = ST_IDLE;
      ST_LOAD_RK:  state_d = ST_RK_ADDR;
      ST_RK_ADDR:  state_d = ST_RK_CAP;
      ST_RK_CAP:   state_d = ST_RK_SCAN;
      ST_RK_SCAN: begin
        if (sts_i.sweep_done) begin
          state_d = ST_RK_WR;
        end
      end
      ST_RK_WR:    state_d = sts_i.i_last ? ST_RK_DONE : ST_RK_ADDR;
      ST_RK_DONE:  state_d = ST_OUT;
      ST_SEL_M1:   state_d = ST_SEL_M2;
      ST_SEL_M2:   state_d = ST_SEL_WALK;
      ST_SEL_WALK: begin
        if (sts_i.hit || sts_i.sweep_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.cap_in  = accept;
      end
      ST_LOAD:    cmd_o.load_we = 1'b1;
      ST_LOAD_RK: begin
        cmd_o.load_we = 1'b1;
        cmd_o.i_clr   = 1'b1;
      end
      ST_RK_ADDR: cmd_o.rd_i = 1'b1;
      ST_RK_CAP: begin
        cmd_o.cap_fi    = 1'b1;
        cmd_o.sweep_clr = 1'b1;
      end
      ST_RK_SCAN: cmd_o.sweep_run = 1'b1;
      ST_RK_WR: begin
        cmd_o.rank_we = 1'b1;
        cmd_o.i_inc   = 1'b1;
      end
      ST_RK_DONE: cmd_o.res_fit = 1'b1;
      ST_SEL_M1:  cmd_o.mul1 = 1'b1;
      ST_SEL_M2: begin
        cmd_o.mul2      = 1'b1;
        cmd_o.sweep_clr = 1'b1;
      end
      ST_SEL_WALK: begin
        cmd_o.sweep_run = 1'b1;
        cmd_o.sel_mode  = 1'b1;
        cmd_o.res_found = sts_i.hit;
        cmd_o.res_nf    = !sts_i.hit && sts_i.sweep_done;
      end
      ST_OUT:     cmd_o.push = !sts_i.out_busy;
      default:    cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/rwps_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_dpath
// Stores, configuration registers, comparison and weight arithmetic, and the
// output register.
// ----------------------------------------------------------------------------
module rwps_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_index_i,
  input  logic [8:0]                           cfg_data_i,
  input  logic [rwps_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [rwps_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic                                 m_tuser_o,
  input  rwps_pkg::dp_cmd_t                    cmd_i,
  output rwps_pkg::dp_sts_t                    sts_o
);
  import rwps_pkg::*;

  localparam int TW = CW + 3;
  localparam int PW = TW + 10;

  // Configuration registers.
  logic [7:0] pop_q;
  logic [8:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q   <= 8'd50;
      slope_q <= 9'd128;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_POP_SIZE) begin
        pop_q <= cfg_data_i[7:0];
      end else begin
        slope_q <= cfg_data_i;
      end
    end
  end

  // Saturated population size and slope.
  logic [CW-1:0] n;
  logic [8:0]    slope_sat;

  always_comb begin
    if (int'(pop_q) < 2) begin
      n = CW'(2);
    end else if (int'(pop_q) > MAX_ENTRIES) begin
      n = CW'(MAX_ENTRIES);
    end else begin
      n = CW'(pop_q);
    end
    slope_sat = (slope_q > 9'd256) ? 9'd256 : slope_q;
  end

  // Input item register.
  logic [6:0]         idx_q;
  logic signed [31:0] fit_q;
  logic [15:0]        frac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      idx_q  <= s_tdata_i[6:0];
      fit_q  <= s_tdata_i[38:7];
      frac_q <= s_tdata_i[54:39];
    end
  end

  // Sweep counters: a_q issues reads, d_q tags the data that returns.
  logic [AW-1:0] i_q;
  logic [CW-1:0] a_q;
  logic [AW-1:0] d_q;
  logic          v_q;
  logic          issue;

  assign issue = cmd_i.sweep_run && (a_q < n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      a_q <= '0;
      d_q <= '0;
      v_q <= 1'b0;
    end else begin
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + AW'(1);
      end
      if (cmd_i.sweep_clr) begin
        a_q <= '0;
        v_q <= 1'b0;
      end else if (cmd_i.sweep_run) begin
        v_q <= issue;
        d_q <= a_q[AW-1:0];
        if (issue) begin
          a_q <= a_q + CW'(1);
        end
      end else begin
        v_q <= 1'b0;
      end
    end
  end

  // Stores.
  logic [31:0]   f_rdata;
  logic [7:0]    r_rdata;
  logic [AW-1:0] f_raddr;
  logic [CW-1:0] above_q;
  logic [7:0]    rank_new;
  logic          f_we;

  assign f_raddr  = cmd_i.rd_i ? i_q : a_q[AW-1:0];
  assign rank_new = 8'(above_q + CW'(1));
  assign f_we     = cmd_i.load_we && (int'(idx_q) < MAX_ENTRIES);

  rwps_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_fit_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (AW'(idx_q)),
    .wdata_i (fit_q),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  rwps_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rank_we),
    .waddr_i (i_q),
    .wdata_i (rank_new),
    .raddr_i (a_q[AW-1:0]),
    .rdata_o (r_rdata)
  );

  // Ranking: count entries that rank above entry i.
  logic signed [31:0] fi_q;
  logic               above_hit;
  logic [6:0]         best_q;

  assign above_hit = ($signed(f_rdata) > fi_q) || (($signed(f_rdata) == fi_q) && (d_q > i_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_fi) begin
      fi_q <= f_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= '0;
      best_q  <= '0;
    end else begin
      if (cmd_i.sweep_clr) begin
        above_q <= '0;
      end else if (cmd_i.sweep_run && !cmd_i.sel_mode && v_q && above_hit) begin
        above_q <= above_q + CW'(1);
      end
      if (cmd_i.rank_we && (above_q == '0)) begin
        best_q <= 7'(i_q);
      end
    end
  end

  // Selection: scaled dice and running weight sum.
  logic [NW-1:0]          nn_q;
  logic [DW-1:0]          dice_q;
  logic signed [SUMW-1:0] sum_q;
  logic [CW:0]            np1;
  logic signed [TW-1:0]   t;
  logic signed [9:0]      sl;
  logic signed [PW-1:0]   prod;
  logic signed [SUMW-1:0] wgt;
  logic signed [SUMW-1:0] sum_new;
  logic                   sel_hit;

  assign np1     = {1'b0, n} + (CW+1)'(1);
  assign t       = $signed(TW'(np1)) - $signed(TW'({r_rdata, 1'b0}));
  assign sl      = $signed({1'b0, slope_sat});
  assign prod    = t * sl;
  assign wgt     = $signed(SUMW'({np1, 8'b0})) + SUMW'(prod);
  assign sum_new = sum_q + wgt;
  assign sel_hit = $signed({sum_new, 8'b0}) >= $signed(CMPW'(dice_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      nn_q <= NW'(n) * NW'(np1);
    end
    if (cmd_i.mul2) begin
      dice_q <= DW'(frac_q) * DW'(nn_q);
    end
    if (cmd_i.sweep_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sweep_run && cmd_i.sel_mode && v_q) begin
      sum_q <= sum_new;
    end
  end

  // Result holding register and output register.
  logic       res_kind_q;
  logic [6:0] res_idx_q;
  logic       res_nf_q;
  logic       m_valid_q;
  logic       m_kind_q;
  logic [6:0] m_idx_q;
  logic       m_nf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_fit) begin
      res_kind_q <= KIND_FITTEST;
      res_idx_q  <= best_q;
      res_nf_q   <= 1'b0;
    end else if (cmd_i.res_found) begin
      res_kind_q <= KIND_PARENT;
      res_idx_q  <= 7'(d_q);
      res_nf_q   <= 1'b0;
    end else if (cmd_i.res_nf) begin
      res_kind_q <= KIND_PARENT;
      res_idx_q  <= 7'd0;
      res_nf_q   <= 1'b1;
    end
    if (cmd_i.push) begin
      m_kind_q <= res_kind_q;
      m_idx_q  <= res_idx_q;
      m_nf_q   <= res_nf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {m_nf_q, m_idx_q};
  assign m_tuser_o  = m_kind_q;

  // Status to the controller.
  assign sts_o.sweep_done = (a_q >= n) && !v_q;
  assign sts_o.hit        = v_q && sel_hit;
  assign sts_o.i_last     = (CW'(i_q) == (n - CW'(1)));
  assign sts_o.out_busy   = m_valid_q && !m_tready_i;

endmodule

FILE: sv/rank_weighted_parent_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_weighted_parent_select
// Linear rank roulette parent selection over a loaded fitness population.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes items: tuser is the operation (load or select),
//   tlast marks the final load, tdata packs entry_index, fitness_value and
//   dice_fraction. A load returns nothing unless tlast is set; the final
//   load then ranks all N entries with one fitness memory read per cycle
//   during each entry's scan, and returns the fittest entry. A select
//   scales the dice by multiplying N by N+1 and then by dice_fraction, and
//   walks the rank memory one entry per cycle until the chosen entry is
//   found or all N entries are passed. One item is worked on at a time.
//   Results leave through an output register on the master stream; a new
//   item is accepted while a result waits there, and the block holds its
//   next result until the receiver takes the pending one.
//   The configuration channel is always ready and writes pop_size (index 0)
//   or fitness_slope (index 1). Reset restores pop_size 50, slope 128 and
//   clears best_entry; the stores are not cleared.
// ----------------------------------------------------------------------------
module rank_weighted_parent_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [8:0]                          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: entry_index[6:0], fitness_value[38:7], dice_fraction[54:39], zero
  input  logic [rwps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: op
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: result_index[6:0], not_found[7]
  output logic [rwps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: result_kind
  output logic                                m_axis_tuser
);
  import rwps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rwps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwps_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: sv/rwps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_checker
// Port level checks for the rank weighted parent select block.
// ----------------------------------------------------------------------------
module rwps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);
  import rwps_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A miss always reports entry zero.
  a_miss_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6:0] == 7'd0)
    else $error("not_found with nonzero index");

  // A fittest report is never a miss.
  a_fit_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FITTEST) |-> !m_axis_tdata[7])
    else $error("fittest report flagged not_found");

endmodule

bind rank_weighted_parent_select rwps_checker u_rwps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
